FILE: hw/rtl/dvpd_pkg.sv
// Shared types and constants for the delta varint point decoder.
`default_nettype none

package dvpd_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ChunkBits  = 5;
  localparam int unsigned CountWidth = 3;

  localparam logic [CharWidth-1:0]  CharOffset = 8'd63;
  localparam logic [CountWidth-1:0] MaxChunks  = 3'd7;

  typedef struct packed {
    logic [CharWidth-1:0] code_char;
    logic                 start_of_line;
  } in_req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] latitude;
    logic signed [CoordWidth-1:0] longitude;
  } out_rsp_t;

  typedef struct packed {
    logic [CoordWidth-1:0] value_accumulator;
    logic [CountWidth-1:0] chunk_count;
    logic                  doing_longitude;
    logic [CoordWidth-1:0] pending_latitude_delta;
    logic [CoordWidth-1:0] running_latitude;
    logic [CoordWidth-1:0] running_longitude;
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/delta_varint_point_decoder_core.sv
// Top level of the encoded polyline point decoder.
`default_nettype none

// The decoder takes one character of an encoded polyline per request and returns a point
// (latitude, longitude in 1e-5 degree, wrapping 32-bit) each time a longitude value
// completes. A request with start_of_line set clears the running point and any partial
// value before its character is decoded. Each character passes an input register and the
// decode logic, and a finished point is held in the result register. A new character is
// taken every cycle unless input is held off, which happens only while a point waits in
// the result register and the sink is not ready.
module delta_varint_point_decoder_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dvpd_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dvpd_pkg::out_rsp_t      out_rsp_o
);

  logic               s1_valid_q;
  dvpd_pkg::in_req_t  s1_req_q;
  dvpd_pkg::state_t   state_q;
  dvpd_pkg::state_t   state_d;
  logic               emit;
  logic               out_free;
  logic               s1_go;
  logic               out_valid_q;
  dvpd_pkg::out_rsp_t out_rsp_q;

  dvpd_step u_step (
    .state_i (state_q),
    .req_i   (s1_req_q),
    .state_o (state_d),
    .emit_o  (emit)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (out_free || !emit);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go) begin
        state_q <= state_d;
      end
      if (s1_go && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
    if (s1_go && emit) begin
      out_rsp_q.latitude  <= state_d.running_latitude;
      out_rsp_q.longitude <= state_d.running_longitude;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dvpd_step.sv
// Per-character decode step: chunk accumulation, zigzag decode and coordinate update.
`default_nettype none

module dvpd_step (
  input  wire dvpd_pkg::state_t  state_i,
  input  wire dvpd_pkg::in_req_t req_i,
  output dvpd_pkg::state_t       state_o,
  output logic                   emit_o
);

  dvpd_pkg::state_t                     base;
  logic [dvpd_pkg::CharWidth-1:0]       diff;
  logic                                 more;
  logic [dvpd_pkg::CoordWidth-1:0]      chunk;
  logic [dvpd_pkg::CoordWidth-1:0]      acc;
  logic [dvpd_pkg::CountWidth-1:0]      cnt;
  logic [4:0]                           shamt;
  logic [dvpd_pkg::CoordWidth-1:0]      folded;
  logic [dvpd_pkg::CoordWidth-1:0]      delta;

  always_comb begin
    base = state_i;
    if (req_i.start_of_line) begin
      base = '0;
    end

    diff  = req_i.code_char - dvpd_pkg::CharOffset;
    more  = !diff[7] && (diff[6] || diff[5]);
    chunk = {{(dvpd_pkg::CoordWidth - dvpd_pkg::ChunkBits){1'b0}},
             diff[dvpd_pkg::ChunkBits-1:0]};
    shamt = {2'b00, base.chunk_count} * 5'd5;

    acc = base.value_accumulator;
    cnt = base.chunk_count;
    if (base.chunk_count < dvpd_pkg::MaxChunks) begin
      acc = acc | (chunk << shamt);
      cnt = cnt + 3'd1;
    end

    // Zigzag decode: odd values are negative.
    folded = acc[0] ? ~acc : acc;
    delta  = {folded[dvpd_pkg::CoordWidth-1], folded[dvpd_pkg::CoordWidth-1:1]};

    state_o = base;
    emit_o  = 1'b0;
    if (more) begin
      state_o.value_accumulator = acc;
      state_o.chunk_count       = cnt;
    end else begin
      state_o.value_accumulator = '0;
      state_o.chunk_count       = '0;
      if (!base.doing_longitude) begin
        state_o.pending_latitude_delta = delta;
        state_o.doing_longitude        = 1'b1;
      end else begin
        state_o.running_latitude       = base.running_latitude + base.pending_latitude_delta;
        state_o.running_longitude      = base.running_longitude + delta;
        state_o.pending_latitude_delta = '0;
        state_o.doing_longitude        = 1'b0;
        emit_o                         = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dvpd_checker.sv
// Port-level assertions for the point decoder and the bind that attaches them.
`default_nettype none

module dvpd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire dvpd_pkg::in_req_t  in_req_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire dvpd_pkg::out_rsp_t out_rsp_o
);

  // A pending point stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("point dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("point changed while stalled");

  // Input is held off only by a stalled point.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A new point follows a taken request, and a line start never finishes a point.
  a_point_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && !in_req_i.start_of_line, 2))
    else $error("point appeared without a finishing request");

endmodule

bind delta_varint_point_decoder_core dvpd_checker u_dvpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

FILE: bench/delta_varint_point_decoder_core_tb.sv
// Self-checking testbench for the encoded polyline point decoder core.
`timescale 1ns / 1ps

module delta_varint_point_decoder_core_tb;

  localparam logic [dvpd_pkg::CharWidth-1:0] ContinueMark = 8'h20;
  localparam logic [dvpd_pkg::CharWidth-1:0] SignMark     = 8'h80;
  localparam int unsigned                    ChunkMask    = 32'h1f;

  class point_scoreboard;
    dvpd_pkg::out_rsp_t              expected_points[$];
    int                              failures      = 0;
    logic [dvpd_pkg::CoordWidth-1:0] value_acc     = '0;
    logic [dvpd_pkg::CountWidth-1:0] chunk_cnt     = '0;
    bit                              on_longitude  = 1'b0;
    logic [dvpd_pkg::CoordWidth-1:0] lat_delta     = '0;
    logic [dvpd_pkg::CoordWidth-1:0] lat_sum       = '0;
    logic [dvpd_pkg::CoordWidth-1:0] lon_sum       = '0;

    function void note_char(dvpd_pkg::in_req_t req);
      logic [dvpd_pkg::CharWidth-1:0]  diff;
      logic [dvpd_pkg::CoordWidth-1:0] zz;
      logic [dvpd_pkg::CoordWidth-1:0] delta;
      bit                              more;
      dvpd_pkg::out_rsp_t              pt;
      if (req.start_of_line) begin
        value_acc    = '0;
        chunk_cnt    = '0;
        on_longitude = 1'b0;
        lat_delta    = '0;
        lat_sum      = '0;
        lon_sum      = '0;
      end
      diff = req.code_char - dvpd_pkg::CharOffset;
      more = (diff >= ContinueMark) && (diff < SignMark);
      if (chunk_cnt < dvpd_pkg::MaxChunks) begin
        value_acc = value_acc | ((dvpd_pkg::CoordWidth'(diff) & ChunkMask)
                                 << (chunk_cnt * dvpd_pkg::ChunkBits));
        chunk_cnt = chunk_cnt + 1'b1;
      end
      if (more) return;
      zz = value_acc;
      if (zz[0]) zz = ~zz;
      delta     = {zz[dvpd_pkg::CoordWidth-1], zz[dvpd_pkg::CoordWidth-1:1]};
      value_acc = '0;
      chunk_cnt = '0;
      if (!on_longitude) begin
        lat_delta    = delta;
        on_longitude = 1'b1;
        return;
      end
      lat_sum      = lat_sum + lat_delta;
      lon_sum      = lon_sum + delta;
      lat_delta    = '0;
      on_longitude = 1'b0;
      pt.latitude  = lat_sum;
      pt.longitude = lon_sum;
      expected_points = {expected_points, pt};
    endfunction

    function void check_point(dvpd_pkg::out_rsp_t got);
      dvpd_pkg::out_rsp_t want;
      if (expected_points.size() == 0) begin
        $error("unexpected point: latitude %0d, longitude %0d", got.latitude, got.longitude);
        failures++;
        return;
      end
      want = expected_points.pop_front();
      if (got.latitude !== want.latitude) begin
        $error("latitude mismatch: expected %0d, actual %0d", want.latitude, got.latitude);
        failures++;
      end
      if (got.longitude !== want.longitude) begin
        $error("longitude mismatch: expected %0d, actual %0d", want.longitude, got.longitude);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  dvpd_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  dvpd_pkg::out_rsp_t out_rsp_o;

  point_scoreboard sb = new();
  bit              quiet_tail = 1'b0;
  int              chars_sent = 0;

  delta_varint_point_decoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_char(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_point(out_rsp_o);
    end
  end

  task automatic send_char(input dvpd_pkg::in_req_t req);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_encoded_value(input logic [dvpd_pkg::CoordWidth-1:0] value,
                                    input bit restart);
    logic [dvpd_pkg::CoordWidth-1:0] rest;
    dvpd_pkg::in_req_t               req;
    rest              = value;
    req.start_of_line = restart;
    while (rest >= 32) begin
      req.code_char     = {3'b001, rest[4:0]} + dvpd_pkg::CharOffset;
      send_char(req);
      req.start_of_line = 1'b0;
      rest              = rest >> dvpd_pkg::ChunkBits;
    end
    req.code_char = {3'b000, rest[4:0]} + dvpd_pkg::CharOffset;
    send_char(req);
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [dvpd_pkg::CharWidth-1:0] corner_bytes[$];
    string                          sample_line;
    dvpd_pkg::in_req_t              req;
    bit                             paused;
    int                             pick;

    paused     = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte extremes, both sides of the continuation boundary, then an overlong value.
    corner_bytes = '{8'h00, 8'hff, 8'd94, 8'd95, 8'd190, 8'd191,
                     8'd190, 8'd190, 8'd190, 8'd190, 8'd190, 8'd190, 8'd190, 8'd190,
                     8'd94, 8'd95};
    foreach (corner_bytes[i]) begin
      req.code_char     = corner_bytes[i];
      req.start_of_line = (i == 0);
      send_char(req);
    end
    // The start flag lands in the middle of an unfinished value.
    sample_line = "_p~iF~ps|U_ulLnnqC";
    for (int i = 0; i < sample_line.len(); i++) begin
      req.code_char     = sample_line[i];
      req.start_of_line = (i == 0);
      send_char(req);
    end

    while (chars_sent < 620) begin
      if (chars_sent >= 520) quiet_tail = 1'b1;
      if (!paused && chars_sent >= 320) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.expected_points.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        req.code_char     = dvpd_pkg::CharWidth'($urandom_range(0, 255));
        req.start_of_line = ($urandom_range(0, 7) == 0);
        send_char(req);
      end else if (pick < 20) begin
        send_encoded_value($urandom, $urandom_range(0, 19) == 0);
      end else begin
        send_encoded_value($urandom >> $urandom_range(0, 31), $urandom_range(0, 39) == 0);
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.expected_points.size() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dvpd_pkg.sv
hw/rtl/dvpd_step.sv
hw/rtl/delta_varint_point_decoder_core.sv
hw/rtl/dvpd_checker.sv
bench/delta_varint_point_decoder_core_tb.sv
